FILE: hdl/lr_pkg.sv
// Shared constants, types and descriptor layout for the line rasterizer.
package lr_pkg;

  localparam int unsigned SCREEN_WIDTH  = 320;
  localparam int unsigned SCREEN_HEIGHT = 200;
  localparam int unsigned PIX_COUNT     = SCREEN_WIDTH * SCREEN_HEIGHT;

  localparam int unsigned X_IDX_W = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
  localparam int unsigned Y_IDX_W = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
  localparam int unsigned ADDR_W  = (PIX_COUNT > 1) ? $clog2(PIX_COUNT) : 1;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned POS_W   = COORD_W + 2;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned ERR_W   = LEN_W + 3;
  localparam int unsigned COUNT_W = LEN_W + 1;
  localparam int unsigned COLOR_W = 8;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_DRAW   = 2'd0,
    KIND_READ   = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e                      kind;
    logic                       vert;
    logic                       step_en;
    logic                       step_neg;
    logic signed [COORD_W-1:0]  x0;
    logic signed [COORD_W-1:0]  y0;
    logic        [LEN_W-1:0]    major;
    logic        [LEN_W-1:0]    minor;
    logic        [COLOR_W-1:0]  color;
  } desc_t;

endpackage

FILE: hdl/lr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module lr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/lr_fifo.sv
// Short descriptor queue between the classifying front and the tracing back.
module lr_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lr_pkg::desc_t desc_i,
  output logic          full_o,
  input  logic          pop_i,
  output lr_pkg::desc_t desc_o,
  output logic          empty_o
);

  lr_pkg::desc_t                   entry_q [lr_pkg::FIFO_DEPTH];
  logic [lr_pkg::FIFO_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [lr_pkg::FIFO_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [lr_pkg::FIFO_CNT_W-1:0]   cnt_q, cnt_d;
  logic                            do_push, do_pop;

  assign full_o  = (cnt_q == lr_pkg::FIFO_CNT_W'(lr_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign desc_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == lr_pkg::FIFO_PTR_W'(lr_pkg::FIFO_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == lr_pkg::FIFO_PTR_W'(lr_pkg::FIFO_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= desc_i;
    end
  end

endmodule

FILE: hdl/lr_front.sv
// Front end: takes requests, rejects trivial lines and sets up the trace descriptor.
module lr_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               hold_i,
  input  logic                               push_i,
  output logic                               full_o,
  input  logic                               command_i,
  input  logic signed [lr_pkg::COORD_W-1:0]  start_x_i,
  input  logic signed [lr_pkg::COORD_W-1:0]  start_y_i,
  input  logic signed [lr_pkg::COORD_W-1:0]  end_x_i,
  input  logic signed [lr_pkg::COORD_W-1:0]  end_y_i,
  input  logic        [lr_pkg::COLOR_W-1:0]  draw_color_i,
  output logic                               q_push_o,
  output lr_pkg::desc_t                      q_desc_o,
  input  logic                               q_full_i
);

  localparam logic signed [lr_pkg::COORD_W:0] WIDTH_S  =
    (lr_pkg::COORD_W + 1)'(lr_pkg::SCREEN_WIDTH);
  localparam logic signed [lr_pkg::COORD_W:0] HEIGHT_S =
    (lr_pkg::COORD_W + 1)'(lr_pkg::SCREEN_HEIGHT);

  logic                               s_valid_q, s_valid_d;
  logic                               cmd_q;
  logic signed [lr_pkg::COORD_W-1:0]  ax_q, ay_q, bx_q, by_q;
  logic        [lr_pkg::COLOR_W-1:0]  color_q;
  logic                               accept;

  logic signed [lr_pkg::COORD_W:0]    ax_w, ay_w, bx_w, by_w;
  logic signed [lr_pkg::COORD_W:0]    dx, dy, ndx, ndy;
  logic        [lr_pkg::LEN_W-1:0]    adx, ady;
  logic                               vert, swap, reject;

  assign full_o   = hold_i || (s_valid_q && q_full_i);
  assign accept   = push_i && !full_o;
  assign q_push_o = s_valid_q && !q_full_i;

  always_comb begin
    s_valid_d = s_valid_q;
    if (accept) begin
      s_valid_d = 1'b1;
    end else if (q_push_o) begin
      s_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else begin
      s_valid_q <= s_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= command_i;
      ax_q    <= start_x_i;
      ay_q    <= start_y_i;
      bx_q    <= end_x_i;
      by_q    <= end_y_i;
      color_q <= draw_color_i;
    end
  end

  // Deltas need one extra bit; their magnitudes always fit in the length width.
  always_comb begin
    ax_w   = (lr_pkg::COORD_W + 1)'(ax_q);
    ay_w   = (lr_pkg::COORD_W + 1)'(ay_q);
    bx_w   = (lr_pkg::COORD_W + 1)'(bx_q);
    by_w   = (lr_pkg::COORD_W + 1)'(by_q);
    dx     = bx_w - ax_w;
    dy     = by_w - ay_w;
    ndx    = -dx;
    ndy    = -dy;
    adx    = dx[lr_pkg::COORD_W] ? ndx[lr_pkg::LEN_W-1:0] : dx[lr_pkg::LEN_W-1:0];
    ady    = dy[lr_pkg::COORD_W] ? ndy[lr_pkg::LEN_W-1:0] : dy[lr_pkg::LEN_W-1:0];
    vert   = ady > adx;
    swap   = vert ? dy[lr_pkg::COORD_W] : dx[lr_pkg::COORD_W];
    reject = ((ax_w >= WIDTH_S) && (bx_w >= WIDTH_S)) ||
             ((ay_w >= HEIGHT_S) && (by_w >= HEIGHT_S));

    q_desc_o.vert  = vert;
    q_desc_o.color = color_q;
    q_desc_o.major = vert ? ady : adx;
    q_desc_o.minor = vert ? adx : ady;
    if (vert) begin
      q_desc_o.step_en  = (dx != '0);
      q_desc_o.step_neg = dx[lr_pkg::COORD_W] ^ swap;
    end else begin
      q_desc_o.step_en  = (dy != '0);
      q_desc_o.step_neg = dy[lr_pkg::COORD_W] ^ swap;
    end

    if (cmd_q) begin
      q_desc_o.kind = lr_pkg::KIND_READ;
      q_desc_o.x0   = ax_q;
      q_desc_o.y0   = ay_q;
    end else if (reject) begin
      q_desc_o.kind = lr_pkg::KIND_REJECT;
      q_desc_o.x0   = ax_q;
      q_desc_o.y0   = ay_q;
    end else begin
      q_desc_o.kind = lr_pkg::KIND_DRAW;
      q_desc_o.x0   = swap ? bx_q : ax_q;
      q_desc_o.y0   = swap ? by_q : ay_q;
    end
  end

endmodule

FILE: hdl/lr_back.sv
// Back end: clears the frame store, traces lines pixel by pixel, serves reads.
module lr_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  output logic                               clearing_o,
  input  logic                               q_empty_i,
  input  lr_pkg::desc_t                      q_desc_i,
  output logic                               q_pop_o,
  input  logic                               pop_i,
  output logic                               empty_o,
  output logic        [lr_pkg::COLOR_W-1:0]  pixel_value_o,
  output logic        [lr_pkg::COUNT_W-1:0]  pixels_written_o,
  output logic                               rejected_o
);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_DRAW   = 5'b00100,
    ST_RDWAIT = 5'b01000,
    ST_FIN    = 5'b10000
  } state_e;

  state_e                             state_q, state_d;
  logic        [lr_pkg::ADDR_W-1:0]   clr_q, clr_d;
  logic                               res_valid_q, res_valid_d;

  logic signed [lr_pkg::POS_W-1:0]    x_q, x_d, y_q, y_d;
  logic signed [lr_pkg::ERR_W-1:0]    err_q, err_d, inc_q, inc_d, dec_q, dec_d, thr_q, thr_d;
  logic        [lr_pkg::LEN_W-1:0]    rem_q, rem_d;
  logic        [lr_pkg::COUNT_W-1:0]  count_q, count_d;
  logic                               vert_q, vert_d, step_en_q, step_en_d;
  logic                               step_neg_q, step_neg_d;
  logic                               rd_on_q, rd_on_d, rej_q, rej_d;
  logic        [lr_pkg::COLOR_W-1:0]  color_q, color_d, value_q, value_d;
  logic        [lr_pkg::COLOR_W-1:0]  res_value_q;
  logic        [lr_pkg::COUNT_W-1:0]  res_count_q;
  logic                               res_rej_q, res_load;

  logic signed [lr_pkg::POS_W-1:0]    sel_x, sel_y, minor_delta;
  logic                               on_scr, step_now, can_finish;
  logic        [lr_pkg::ADDR_W-1:0]   pix_addr;
  logic signed [lr_pkg::ERR_W-1:0]    len_s, min_s, diff_s;

  logic                               ram_we;
  logic        [lr_pkg::ADDR_W-1:0]   ram_waddr;
  logic        [lr_pkg::COLOR_W-1:0]  ram_wdata, ram_rdata;

  lr_ram #(
    .WIDTH (lr_pkg::COLOR_W),
    .DEPTH (lr_pkg::PIX_COUNT)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (pix_addr),
    .rdata_o (ram_rdata)
  );

  assign clearing_o = (state_q == ST_CLEAR);
  assign can_finish = !res_valid_q || pop_i;
  assign empty_o    = !res_valid_q;
  assign q_pop_o    = (state_q == ST_IDLE) && !q_empty_i;

  // The read address comes from the queued request while idle, else from the tracer.
  always_comb begin
    if (state_q == ST_IDLE) begin
      sel_x = lr_pkg::POS_W'(q_desc_i.x0);
      sel_y = lr_pkg::POS_W'(q_desc_i.y0);
    end else begin
      sel_x = x_q;
      sel_y = y_q;
    end
    on_scr = (sel_x >= 0) && (sel_y >= 0) &&
             (sel_x < lr_pkg::POS_W'(lr_pkg::SCREEN_WIDTH)) &&
             (sel_y < lr_pkg::POS_W'(lr_pkg::SCREEN_HEIGHT));
    pix_addr = lr_pkg::ADDR_W'(lr_pkg::ADDR_W'(sel_y[lr_pkg::Y_IDX_W-1:0]) *
                               lr_pkg::ADDR_W'(lr_pkg::SCREEN_WIDTH)) +
               lr_pkg::ADDR_W'(sel_x[lr_pkg::X_IDX_W-1:0]);
  end

  // Error step: err + 2M >= L is tested as err >= L - 2M, so add and compare run side by side.
  always_comb begin
    step_now    = (err_q >= thr_q);
    minor_delta = '0;
    if (step_now && step_en_q) begin
      minor_delta = step_neg_q ? -lr_pkg::POS_W'(1) : lr_pkg::POS_W'(1);
    end
    len_s  = $signed(lr_pkg::ERR_W'(q_desc_i.major));
    min_s  = $signed(lr_pkg::ERR_W'(q_desc_i.minor));
    diff_s = min_s - len_s;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pix_addr;
    ram_wdata = color_q;
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else if (state_q == ST_DRAW) begin
      ram_we = on_scr;
    end
  end

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    x_d        = x_q;
    y_d        = y_q;
    err_d      = err_q;
    inc_d      = inc_q;
    dec_d      = dec_q;
    thr_d      = thr_q;
    rem_d      = rem_q;
    count_d    = count_q;
    vert_d     = vert_q;
    step_en_d  = step_en_q;
    step_neg_d = step_neg_q;
    rd_on_d    = rd_on_q;
    rej_d      = rej_q;
    color_d    = color_q;
    value_d    = value_q;
    res_load   = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == lr_pkg::ADDR_W'(lr_pkg::PIX_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty_i) begin
          count_d = '0;
          value_d = '0;
          rej_d   = 1'b0;
          case (q_desc_i.kind)
            lr_pkg::KIND_DRAW: begin
              x_d        = lr_pkg::POS_W'(q_desc_i.x0);
              y_d        = lr_pkg::POS_W'(q_desc_i.y0);
              vert_d     = q_desc_i.vert;
              step_en_d  = q_desc_i.step_en;
              step_neg_d = q_desc_i.step_neg;
              color_d    = q_desc_i.color;
              rem_d      = q_desc_i.major;
              err_d      = '0;
              inc_d      = min_s + min_s;
              dec_d      = diff_s + diff_s;
              thr_d      = len_s - (min_s + min_s);
              state_d    = ST_DRAW;
            end
            lr_pkg::KIND_READ: begin
              rd_on_d = on_scr;
              state_d = ST_RDWAIT;
            end
            lr_pkg::KIND_REJECT: begin
              rej_d   = 1'b1;
              state_d = ST_FIN;
            end
            default: begin
              state_d = ST_FIN;
            end
          endcase
        end
      end
      ST_DRAW: begin
        if (on_scr) begin
          count_d = count_q + 1'b1;
        end
        err_d = step_now ? err_q + dec_q : err_q + inc_q;
        if (vert_q) begin
          x_d = x_q + minor_delta;
          y_d = y_q + lr_pkg::POS_W'(1);
        end else begin
          x_d = x_q + lr_pkg::POS_W'(1);
          y_d = y_q + minor_delta;
        end
        rem_d = rem_q - 1'b1;
        if (rem_q == '0) begin
          state_d = ST_FIN;
        end
      end
      ST_RDWAIT: begin
        value_d = rd_on_q ? ram_rdata : '0;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (can_finish) begin
          res_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (pop_i && res_valid_q) begin
      res_valid_d = 1'b0;
    end
    if (res_load) begin
      res_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    y_q        <= y_d;
    err_q      <= err_d;
    inc_q      <= inc_d;
    dec_q      <= dec_d;
    thr_q      <= thr_d;
    rem_q      <= rem_d;
    count_q    <= count_d;
    vert_q     <= vert_d;
    step_en_q  <= step_en_d;
    step_neg_q <= step_neg_d;
    rd_on_q    <= rd_on_d;
    rej_q      <= rej_d;
    color_q    <= color_d;
    value_q    <= value_d;
    if (res_load) begin
      res_value_q <= value_q;
      res_count_q <= count_q;
      res_rej_q   <= rej_q;
    end
  end

  assign pixel_value_o    = res_value_q;
  assign pixels_written_o = res_count_q;
  assign rejected_o       = res_rej_q;

endmodule

FILE: hdl/line_rasterizer.sv
// Top level of the Bresenham line rasterizer with its on-chip frame store.
//
//   Channel   Direction  Handshake          Payload
//   request   in         push / full        command, start/end x and y, draw_color
//   result    out        empty / pop        pixel_value, pixels_written, rejected
//
// A draw request passes through the front stage, the queue and the tracer, which writes
// one pixel per cycle through the single write port of the frame store, and finishes
// into the output register, from which it can be popped. A read request takes the same
// path, the tracer's share being the registered read of the frame store.
// After reset the frame store is cleared one byte per cycle, all 64000 entries
// (SCREEN_WIDTH * SCREEN_HEIGHT), and full stays high while it is cleared.
// The front stage and a two-entry queue keep taking requests while a line is traced,
// and a finished result waits in an output register until it is popped; only when
// that register is still occupied does the tracer hold its next result.
module line_rasterizer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic                               command_i,
  input  logic signed [lr_pkg::COORD_W-1:0]  start_x_i,
  input  logic signed [lr_pkg::COORD_W-1:0]  start_y_i,
  input  logic signed [lr_pkg::COORD_W-1:0]  end_x_i,
  input  logic signed [lr_pkg::COORD_W-1:0]  end_y_i,
  input  logic        [lr_pkg::COLOR_W-1:0]  draw_color_i,
  output logic                               empty,
  input  logic                               pop,
  output logic        [lr_pkg::COLOR_W-1:0]  pixel_value_o,
  output logic        [lr_pkg::COUNT_W-1:0]  pixels_written_o,
  output logic                               rejected_o
);

  logic          clearing;
  logic          q_push, q_full, q_pop, q_empty;
  lr_pkg::desc_t q_wdesc, q_rdesc;

  // The front classifies each request: read, trivially rejected line, or line to trace.
  lr_front u_lr_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .hold_i       (clearing),
    .push_i       (push),
    .full_o       (full),
    .command_i    (command_i),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .draw_color_i (draw_color_i),
    .q_push_o     (q_push),
    .q_desc_o     (q_wdesc),
    .q_full_i     (q_full)
  );

  // The queue decouples setup from tracing so each side stalls on its own.
  lr_fifo u_lr_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .desc_i  (q_wdesc),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .desc_o  (q_rdesc),
    .empty_o (q_empty)
  );

  // The back owns the frame store and produces exactly one result per request.
  lr_back u_lr_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .clearing_o       (clearing),
    .q_empty_i        (q_empty),
    .q_desc_i         (q_rdesc),
    .q_pop_o          (q_pop),
    .pop_i            (pop),
    .empty_o          (empty),
    .pixel_value_o    (pixel_value_o),
    .pixels_written_o (pixels_written_o),
    .rejected_o       (rejected_o)
  );

endmodule

FILE: hdl/lr_checker.sv
// Port-level checks on the line rasterizer, bound to its top level.
module lr_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               full,
  input logic                               empty,
  input logic                               pop,
  input logic        [lr_pkg::COLOR_W-1:0]  pixel_value_o,
  input logic        [lr_pkg::COUNT_W-1:0]  pixels_written_o,
  input logic                               rejected_o
);

  // Right after reset the frame store is being cleared and no result can exist.
  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> (full && empty))
    else $error("requests accepted or result shown right after reset");

  // A result that is not taken stays on the ports unchanged.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(pixel_value_o) &&
                          $stable(pixels_written_o) && $stable(rejected_o)))
    else $error("pending result changed before it was popped");

  // A rejected line neither reads nor writes pixels.
  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && rejected_o) |-> (pixel_value_o == '0 && pixels_written_o == '0))
    else $error("rejected result carries pixel data");

  // A read result never reports written pixels.
  a_read_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pixel_value_o != '0) |-> (pixels_written_o == '0 && !rejected_o))
    else $error("read result mixed with draw fields");

endmodule

bind line_rasterizer lr_checker u_lr_checker (.*);

FILE: tb/sv/line_rasterizer_check.sv
// Request and result monitor for the line rasterizer: frame store prediction and result compare.
`timescale 1ns / 1ps

module line_rasterizer_check (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  input  logic                               full,
  input  logic                               command_i,
  input  logic signed [lr_pkg::COORD_W-1:0]  start_x_i,
  input  logic signed [lr_pkg::COORD_W-1:0]  start_y_i,
  input  logic signed [lr_pkg::COORD_W-1:0]  end_x_i,
  input  logic signed [lr_pkg::COORD_W-1:0]  end_y_i,
  input  logic        [lr_pkg::COLOR_W-1:0]  draw_color_i,
  input  logic                               empty,
  input  logic                               pop,
  input  logic        [lr_pkg::COLOR_W-1:0]  pixel_value_o,
  input  logic        [lr_pkg::COUNT_W-1:0]  pixels_written_o,
  input  logic                               rejected_o,
  output int                                 mismatches = 0,
  output int                                 outstanding = 0,
  output int                                 results_checked = 0
);

  // Signed copies of the screen size, so that negative coordinates compare correctly.
  localparam int WIDTH_PX  = lr_pkg::SCREEN_WIDTH;
  localparam int HEIGHT_PX = lr_pkg::SCREEN_HEIGHT;

  typedef struct packed {
    logic [lr_pkg::COLOR_W-1:0] pixel;
    logic [lr_pkg::COUNT_W-1:0] written;
    logic                       rejected;
  } outcome_t;

  logic [lr_pkg::COLOR_W-1:0] frame_model [lr_pkg::PIX_COUNT];
  outcome_t                   expected_outcomes [$];
  int                         errors;
  int                         checked;

  function automatic bit on_screen(int x, int y);
    return x >= 0 && y >= 0 && x < WIDTH_PX && y < HEIGHT_PX;
  endfunction

  // Walks the line with an exact integer error term scaled by twice the major length
  // and paints the frame model; returns the number of pixels that landed on screen.
  function automatic int unsigned paint_line(int x0, int y0, int x1, int y1,
                                             logic [lr_pkg::COLOR_W-1:0] color);
    int          dx, dy, adx, ady, swap, minor_step, x, y;
    bit          vert;
    longint      major_len, minor_len, err;
    int unsigned plotted;
    dx   = x1 - x0;
    dy   = y1 - y0;
    adx  = (dx < 0) ? -dx : dx;
    ady  = (dy < 0) ? -dy : dy;
    vert = ady > adx;
    if (vert ? (y1 < y0) : (x1 < x0)) begin
      swap = x0; x0 = x1; x1 = swap;
      swap = y0; y0 = y1; y1 = swap;
      dx = -dx;
      dy = -dy;
    end
    major_len  = vert ? ady : adx;
    minor_len  = vert ? adx : ady;
    if (vert) minor_step = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
    else      minor_step = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
    err     = 0;
    plotted = 0;
    x       = x0;
    y       = y0;
    for (longint k = 0; k <= major_len; k++) begin
      if (on_screen(x, y)) begin
        frame_model[y * WIDTH_PX + x] = color;
        plotted++;
      end
      err += 2 * minor_len;
      if (err >= major_len) begin
        if (vert) x += minor_step;
        else      y += minor_step;
        err -= 2 * major_len;
      end
      if (vert) y++;
      else      x++;
    end
    return plotted;
  endfunction

  function automatic outcome_t predict_outcome(lr_pkg::kind_e kind,
                                               int ax, int ay, int bx, int by,
                                               logic [lr_pkg::COLOR_W-1:0] color);
    outcome_t res;
    res = '0;
    if (kind == lr_pkg::KIND_READ) begin
      if (on_screen(ax, ay)) res.pixel = frame_model[ay * WIDTH_PX + ax];
    end else if ((ax >= WIDTH_PX && bx >= WIDTH_PX) || (ay >= HEIGHT_PX && by >= HEIGHT_PX)) begin
      res.rejected = 1'b1;
    end else begin
      res.written = lr_pkg::COUNT_W'(paint_line(ax, ay, bx, by, color));
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t seen;
    outcome_t want;
    if (!rst_ni) begin
      foreach (frame_model[i]) frame_model[i] = '0;
      expected_outcomes.delete();
      errors  = 0;
      checked = 0;
    end else begin
      if (pop && !empty) begin
        seen = '{pixel: pixel_value_o, written: pixels_written_o, rejected: rejected_o};
        if (expected_outcomes.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, actual pixel %0d written %0d %s %0b",
                   $time, seen.pixel, seen.written, "rejected", seen.rejected);
        end else begin
          want = expected_outcomes.pop_front();
          checked++;
          if (seen.pixel !== want.pixel) begin
            errors++;
            $display("%0t: result %0d pixel_value: expected %0d, actual %0d",
                     $time, checked, want.pixel, seen.pixel);
          end
          if (seen.written !== want.written) begin
            errors++;
            $display("%0t: result %0d pixels_written: expected %0d, actual %0d",
                     $time, checked, want.written, seen.written);
          end
          if (seen.rejected !== want.rejected) begin
            errors++;
            $display("%0t: result %0d rejected: expected %0b, actual %0b",
                     $time, checked, want.rejected, seen.rejected);
          end
        end
      end
      if (push && !full) begin
        expected_outcomes.push_back(predict_outcome(
          command_i ? lr_pkg::KIND_READ : lr_pkg::KIND_DRAW,
          start_x_i, start_y_i, end_x_i, end_y_i, draw_color_i));
      end
    end
    mismatches      <= errors;
    outstanding     <= expected_outcomes.size();
    results_checked <= checked;
  end

endmodule

FILE: tb/sv/line_rasterizer_tb.sv
// Top of the line rasterizer testbench: clock, reset, request and result traffic, verdict.
`timescale 1ns / 1ps

module line_rasterizer_tb;

  localparam int          WIDTH_PX        = lr_pkg::SCREEN_WIDTH;
  localparam int          HEIGHT_PX       = lr_pkg::SCREEN_HEIGHT;
  localparam int          RANDOM_REQUESTS = 950;
  // The slowest correct run is roughly the clear of the frame store, two full-length
  // lines and the random lines, stretched by output stalls and request gaps. The limit
  // is several times that.
  localparam int unsigned CYCLE_LIMIT     = 3_000_000;
  // Long enough for the front stage, the queue, the tracer and the output register
  // to fill up behind a receiver that does not pop.
  localparam int          HOLD_OFF_CYCLES = 3000;
  localparam int          DRAIN_CYCLES    = 20;

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               push;
  logic                               full;
  logic                               command_i;
  logic signed [lr_pkg::COORD_W-1:0]  start_x_i;
  logic signed [lr_pkg::COORD_W-1:0]  start_y_i;
  logic signed [lr_pkg::COORD_W-1:0]  end_x_i;
  logic signed [lr_pkg::COORD_W-1:0]  end_y_i;
  logic        [lr_pkg::COLOR_W-1:0]  draw_color_i;
  logic                               empty;
  logic                               pop;
  logic        [lr_pkg::COLOR_W-1:0]  pixel_value_o;
  logic        [lr_pkg::COUNT_W-1:0]  pixels_written_o;
  logic                               rejected_o;

  int          mismatches;
  int          outstanding;
  int          results_checked;
  int unsigned cycle_count;

  // Sender bookkeeping: how many requests remain in the current burst, what was sent,
  // and the last line start, so that reads can land on freshly painted pixels.
  int burst_left;
  int lines_sent;
  int reads_sent;
  int last_x;
  int last_y;

  line_rasterizer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .command_i        (command_i),
    .start_x_i        (start_x_i),
    .start_y_i        (start_y_i),
    .end_x_i          (end_x_i),
    .end_y_i          (end_y_i),
    .draw_color_i     (draw_color_i),
    .empty            (empty),
    .pop              (pop),
    .pixel_value_o    (pixel_value_o),
    .pixels_written_o (pixels_written_o),
    .rejected_o       (rejected_o)
  );

  line_rasterizer_check raster_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .command_i        (command_i),
    .start_x_i        (start_x_i),
    .start_y_i        (start_y_i),
    .end_x_i          (end_x_i),
    .end_y_i          (end_y_i),
    .draw_color_i     (draw_color_i),
    .empty            (empty),
    .pop              (pop),
    .pixel_value_o    (pixel_value_o),
    .pixels_written_o (pixels_written_o),
    .rejected_o       (rejected_o),
    .mismatches       (mismatches),
    .outstanding      (outstanding),
    .results_checked  (results_checked)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // Any 16-bit pattern, the sign bit included.
  function automatic logic signed [lr_pkg::COORD_W-1:0] rand_coord();
    return lr_pkg::COORD_W'($urandom);
  endfunction

  // Offers one request and waits until the block takes it. Afterwards the sender either
  // carries on in the current burst, keeping push high, or drops push for a random gap
  // and then starts a new burst. Push is only lowered when a gap follows, so it never
  // sees two assignments in one time step.
  task automatic offer_request(lr_pkg::kind_e kind, int ax, int ay, int bx, int by,
                               int color);
    command_i    <= (kind == lr_pkg::KIND_READ);
    start_x_i    <= lr_pkg::COORD_W'(ax);
    start_y_i    <= lr_pkg::COORD_W'(ay);
    end_x_i      <= lr_pkg::COORD_W'(bx);
    end_y_i      <= lr_pkg::COORD_W'(by);
    draw_color_i <= lr_pkg::COLOR_W'(color);
    push         <= 1'b1;
    do @(posedge clk_i); while (full);
    if (kind == lr_pkg::KIND_READ) begin
      reads_sent++;
    end else begin
      lines_sent++;
      last_x = ax;
      last_y = ay;
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      push <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
      // Now and then a long burst, so that stretches without gaps occur as well.
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  // Holds the sender until every result it has asked for has come back. The first
  // edge lets the monitor account for a request taken at the current edge.
  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // Watchdog: a run that has not finished within the limit has hung.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // Result side: pop follows stretches of random length, each with its own stall
  // rate, from always ready to mostly stalled. Once a couple of hundred results have
  // been checked, pop stays low for a long stretch while the sender keeps pushing,
  // so that the block backs up all the way to full.
  initial begin : receiver
    int run_len;
    int stall_pct;
    bit held_off;
    held_off = 1'b0;
    pop <= 1'b0;
    forever begin
      run_len = $urandom_range(1, 64);
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 35;
        default: stall_pct = 80;
      endcase
      repeat (run_len) begin
        @(posedge clk_i);
        pop <= ($urandom_range(0, 99) >= stall_pct);
      end
      if (!held_off && results_checked >= 200) begin
        @(posedge clk_i);
        pop <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        held_off = 1'b1;
      end
    end
  end

  // Request side: reset, a directed pass over the corner cases, then random traffic.
  initial begin : sender
    int pick;
    int shape;
    int ax, ay, bx, by;
    push         <= 1'b0;
    command_i    <= 1'b0;
    start_x_i    <= '0;
    start_y_i    <= '0;
    end_x_i      <= '0;
    end_y_i      <= '0;
    draw_color_i <= '0;
    burst_left = 0;
    lines_sent = 0;
    reads_sent = 0;
    last_x     = 0;
    last_y     = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Full stays high while the frame store is cleared, so the first
    // request simply waits for it. The first read sees the cleared store.
    offer_request(lr_pkg::KIND_READ, 0, 0, 0, 0, 0);
    // Full-width horizontal line along the top row, brightest color.
    offer_request(lr_pkg::KIND_DRAW, 0, 0, WIDTH_PX - 1, 0, 255);
    offer_request(lr_pkg::KIND_READ, WIDTH_PX - 1, 0, 0, 0, 0);
    // Vertical line drawn bottom to top, so the endpoints get swapped.
    offer_request(lr_pkg::KIND_DRAW, WIDTH_PX - 1, HEIGHT_PX - 1, WIDTH_PX - 1, 0, 1);
    offer_request(lr_pkg::KIND_READ, WIDTH_PX - 1, HEIGHT_PX - 1, 0, 0, 0);
    // Equal deltas: x stays the major axis; the minor coordinate steps down.
    offer_request(lr_pkg::KIND_DRAW, 0, HEIGHT_PX - 1, HEIGHT_PX - 1, 0, 128);
    // A single point, then a read of it.
    offer_request(lr_pkg::KIND_DRAW, 5, 5, 5, 5, 85);
    offer_request(lr_pkg::KIND_READ, 5, 5, 0, 0, 0);
    // Trivial rejection on the right edge and on the bottom edge.
    offer_request(lr_pkg::KIND_DRAW, WIDTH_PX, 10, 32767, -32768, 18);
    offer_request(lr_pkg::KIND_DRAW, -32768, HEIGHT_PX, 32767, 32767, 18);
    // Entirely left of and above the screen: traced but paints nothing.
    offer_request(lr_pkg::KIND_DRAW, -100, -5, -1, -50, 200);
    // One pixel inside the right edge keeps the line from being rejected.
    offer_request(lr_pkg::KIND_DRAW, WIDTH_PX - 1, 50, WIDTH_PX + 40, 60, 7);
    // Full-length lines across the whole coordinate range, one diagonal, one steep.
    offer_request(lr_pkg::KIND_DRAW, -32768, -32768, 32767, 32767, 170);
    offer_request(lr_pkg::KIND_DRAW, 0, 32767, 1, -32768, 0);
    // Shallow line whose minor coordinate falls.
    offer_request(lr_pkg::KIND_DRAW, 10, 150, 300, 140, 66);
    offer_request(lr_pkg::KIND_READ, 10, 150, 0, 0, 0);
    // Reads off the left, right and bottom of the screen and at the extremes of the coordinates.
    offer_request(lr_pkg::KIND_READ, -1, 0, 0, 0, 0);
    offer_request(lr_pkg::KIND_READ, WIDTH_PX, HEIGHT_PX - 1, 0, 0, 0);
    offer_request(lr_pkg::KIND_READ, 0, HEIGHT_PX, 0, 0, 0);
    offer_request(lr_pkg::KIND_READ, -32768, 32767, 0, 0, 0);
    offer_request(lr_pkg::KIND_READ, 100, 100, 0, 0, 0);
    drain_results();

    // Random part. Most requests are lines in a window slightly larger than the screen,
    // so that clipping happens on every side; some reads target recently painted pixels.
    // Rejected lines carry random 16-bit coordinates on one axis, and some reads on both,
    // which drive every bit of every field without costing long traces.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == RANDOM_REQUESTS / 2) drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        offer_request(lr_pkg::KIND_DRAW, rand_between(WIDTH_PX, 32767), rand_coord(),
                      rand_between(WIDTH_PX, 32767), rand_coord(), $urandom_range(0, 255));
      end else if (pick < 16) begin
        offer_request(lr_pkg::KIND_DRAW, rand_coord(), rand_between(HEIGHT_PX, 32767),
                      rand_coord(), rand_between(HEIGHT_PX, 32767), $urandom_range(0, 255));
      end else if (pick < 26) begin
        offer_request(lr_pkg::KIND_READ, rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), $urandom_range(0, 255));
      end else if (pick < 38) begin
        offer_request(lr_pkg::KIND_READ, last_x + rand_between(-1, 1),
                      last_y + rand_between(-1, 1), 0, 0, 0);
      end else if (pick < 46) begin
        offer_request(lr_pkg::KIND_READ, rand_between(0, WIDTH_PX - 1),
                      rand_between(0, HEIGHT_PX - 1), 0, 0, 0);
      end else begin
        shape = $urandom_range(0, 99);
        if (shape < 3) begin
          // A few long lines reaching far outside the screen.
          ax = rand_between(-1000, 1400);
          ay = rand_between(-1000, 1200);
          bx = rand_between(-1000, 1400);
          by = rand_between(-1000, 1200);
        end else if (shape < 25) begin
          // Short strokes, points among them.
          ax = rand_between(-4, WIDTH_PX + 3);
          ay = rand_between(-4, HEIGHT_PX + 3);
          bx = ax + rand_between(-8, 8);
          by = ay + rand_between(-8, 8);
        end else begin
          ax = rand_between(-40, WIDTH_PX + 40);
          ay = rand_between(-40, HEIGHT_PX + 40);
          bx = rand_between(-40, WIDTH_PX + 40);
          by = rand_between(-40, HEIGHT_PX + 40);
        end
        offer_request(lr_pkg::KIND_DRAW, ax, ay, bx, by, $urandom_range(0, 255));
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d line draws and %0d pixel reads; %0d results compared.",
             lines_sent, reads_sent, results_checked);
    $display("Covered clipping on all sides, rejection, points, full-range lines, %s",
             "backpressure.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: line_rasterizer.f
hdl/lr_pkg.sv
hdl/lr_ram.sv
hdl/lr_fifo.sv
hdl/lr_front.sv
hdl/lr_back.sv
hdl/line_rasterizer.sv
hdl/lr_checker.sv
tb/sv/line_rasterizer_check.sv
tb/sv/line_rasterizer_tb.sv
